[rtl/core/mi44_pkg.sv]
package mi44_pkg;

	localparam int ELEM_W = 32;
	localparam int N_ELEM = 16;
	localparam int IDX_W  = 4;
	localparam int THR_W  = 31;
	localparam int MIN_W  = 98;
	localparam int DET_W  = 131;
	localparam int NUM_W  = 192;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_MRD,
		ST_MMUL,
		ST_MWAIT,
		ST_DRD,
		ST_DMUL,
		ST_DWAIT,
		ST_CHECK,
		ST_DIVSET,
		ST_DIV,
		ST_EMIT
	} mi44_state_t;

	typedef struct packed {
		logic        start;
		logic [3:0]  k;
	} mi44_div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
	} mi44_div_stat_t;

	function automatic logic [IDX_W-1:0] minor_addr(input logic [3:0] k, input logic [3:0] e);
		logic [1:0] rr, cc, r, c;
		logic [1:0] er, ec;
		begin
			rr = k[3:2];
			cc = k[1:0];
			er = (e >= 4'd6) ? 2'd2 : ((e >= 4'd3) ? 2'd1 : 2'd0);
			ec = 2'(e - 4'({er, 1'b0}) - 4'(er));
			r  = (er >= rr) ? 2'(er + 2'd1) : er;
			c  = (ec >= cc) ? 2'(ec + 2'd1) : ec;
			return {r, c};
		end
	endfunction

endpackage

[rtl/core/matrix_inverse_4x4_top.sv]
// 4x4 inverse by adjugate: load sixteen Q16.16 elements (one request per cycle, row-major),
// then the block computes sixteen 3x3 minors on one shared multiplier that takes a signed
// operand of up to 98 bits times a 32-bit element as four 32x32 limb products, then collects
// the result. Each minor reads its nine elements and takes nine products. The determinant
// takes four products plus a compare. Each quotient runs on a bit-serial restoring divider
// of 192 steps, with a setup step before it and an emit step after it; a singular matrix
// (|det| at or below det_threshold) returns the identity without dividing. A stalled output
// holds the next quotient from starting. Results leave through a one-entry output register.
module matrix_inverse_4x4_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // element
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // inverse_element
	output logic [1:0]  m_tuser,   // singular, saturated
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import mi44_pkg::*;

	mi44_state_t st_q, st_d;
	logic [ELEM_W-1:0] mem [N_ELEM];
	logic [ELEM_W-1:0] rd_q;
	logic [IDX_W-1:0]  ra;
	logic [IDX_W-1:0]  ld_q;
	logic [THR_W-1:0]  thr_q;
	logic signed [MIN_W-1:0] mn_q [N_ELEM];
	logic signed [ELEM_W-1:0] e_q [9];
	logic [3:0]  k_q, e_cnt_q;
	logic [3:0]  ph_q;
	logic signed [MIN_W-1:0] acc_q, t_q, p2_q, p3_q;
	logic signed [DET_W-1:0] det_q;
	logic signed [MIN_W-1:0] ma;
	logic signed [ELEM_W-1:0] mb;
	logic sing_q;
	logic ov_q;
	logic out_fire;
	logic [31:0] od_q;
	logic [1:0]  ou_q;
	logic        ol_q;
	logic [DET_W-1:0] dmag;
	logic [NUM_W-1:0] num;
	logic [NUM_W-1:0] quot;
	mi44_div_req_t  dreq;
	mi44_div_stat_t dstat;

	logic              mul_go;
	logic [MIN_W-1:0]  ma_mag;
	logic [31:0]       mb_mag;
	logic [127:0]      mul_am_q;
	logic [31:0]       mul_bm_q;
	logic              mul_neg_q, mul_busy_q;
	logic [1:0]        mul_cnt_q;
	logic [DET_W-1:0]  mul_acc_q;
	logic [31:0]       mul_limb;
	logic [63:0]       mul_pp;
	logic signed [DET_W-1:0] prod;

	// minor phases: products e4*e8, e5*e7, e3*e8, e5*e6, e3*e7, e4*e6, then row-0 terms
	always_comb begin
		ma = '0;
		mb = '0;
		case (ph_q)
			4'd0: begin ma = MIN_W'(e_q[4]); mb = e_q[8]; end
			4'd1: begin ma = MIN_W'(e_q[5]); mb = e_q[7]; end
			4'd2: begin ma = MIN_W'(e_q[3]); mb = e_q[8]; end
			4'd3: begin ma = MIN_W'(e_q[5]); mb = e_q[6]; end
			4'd4: begin ma = MIN_W'(e_q[3]); mb = e_q[7]; end
			4'd5: begin ma = MIN_W'(e_q[4]); mb = e_q[6]; end
			4'd6: begin ma = t_q;  mb = e_q[0]; end
			4'd7: begin ma = p2_q; mb = e_q[1]; end
			4'd8: begin ma = p3_q; mb = e_q[2]; end
			default: begin ma = '0; mb = '0; end
		endcase
		if (st_q == ST_DMUL) begin
			ma = mn_q[k_q];
			mb = $signed(rd_q);
		end
	end

	// sign-magnitude multiply, one 32-bit limb of the wide operand per cycle, high limb first
	assign mul_go   = (st_q == ST_MMUL) || (st_q == ST_DMUL);
	assign ma_mag   = ma[MIN_W-1] ? MIN_W'(-ma) : MIN_W'(ma);
	assign mb_mag   = mb[ELEM_W-1] ? 32'(-mb) : 32'(mb);
	assign mul_limb = mul_am_q[{mul_cnt_q, 5'd0} +: 32];
	assign mul_pp   = {32'b0, mul_limb} * {32'b0, mul_bm_q};
	assign prod     = mul_neg_q ? -$signed(mul_acc_q) : $signed(mul_acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_cnt_q  <= '0;
		end else if (mul_go) begin
			mul_busy_q <= 1'b1;
			mul_cnt_q  <= 2'd3;
		end else if (mul_busy_q) begin
			mul_cnt_q <= mul_cnt_q - 2'd1;
			if (mul_cnt_q == 2'd0)
				mul_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			mul_am_q  <= 128'(ma_mag);
			mul_bm_q  <= mb_mag;
			mul_neg_q <= ma[MIN_W-1] ^ mb[ELEM_W-1];
			mul_acc_q <= '0;
		end else if (mul_busy_q) begin
			mul_acc_q <= (mul_acc_q << 32) + DET_W'(mul_pp);
		end
	end

	assign s_tready  = (st_q == ST_LOAD);
	assign cfg_ready = 1'b1;
	assign ra = (st_q == ST_LOAD) ? ld_q :
	            (st_q == ST_DRD) ? k_q : minor_addr(k_q, e_cnt_q);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			mem[ld_q] <= s_tdata;
		rd_q <= mem[ra];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_LOAD:   if (s_tvalid && ld_q == 4'd15) st_d = ST_MRD;
			ST_MRD:    if (e_cnt_q == 4'd9) st_d = ST_MMUL;
			ST_MMUL:   st_d = ST_MWAIT;
			ST_MWAIT:  if (!mul_busy_q) begin
				if (ph_q != 4'd8)
					st_d = ST_MMUL;
				else
					st_d = (k_q == 4'd15) ? ST_DRD : ST_MRD;
			end
			ST_DRD:    st_d = ST_DMUL;
			ST_DMUL:   st_d = ST_DWAIT;
			ST_DWAIT:  if (!mul_busy_q) st_d = (k_q == 4'd3) ? ST_CHECK : ST_DRD;
			ST_CHECK:  st_d = ST_DIVSET;
			ST_DIVSET: if (!ov_q || m_tready) st_d = sing_q ? ST_EMIT : ST_DIV;
			ST_DIV:    if (dstat.done) st_d = ST_EMIT;
			ST_EMIT:   if (!ov_q || m_tready) st_d = (k_q == 4'd15) ? ST_LOAD : ST_DIVSET;
			default:   st_d = ST_LOAD;
		endcase
	end

	assign dmag = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);

	logic [3:0] ck;
	logic cneg;
	logic signed [MIN_W-1:0] cf;
	logic [MIN_W-1:0] cabs;
	assign ck   = {k_q[1:0], k_q[3:2]};
	assign cf   = mn_q[ck];
	assign cabs = cf[MIN_W-1] ? MIN_W'(-cf) : MIN_W'(cf);
	assign cneg = cf[MIN_W-1] ^ det_q[DET_W-1] ^ k_q[2] ^ k_q[0];
	assign num  = (NUM_W'(cabs) << (2 * FRAC_BITS + 1)) + NUM_W'(dmag);
	assign dreq.start = (st_q == ST_DIVSET) && (!ov_q || m_tready) && !sing_q;
	assign dreq.k     = k_q;

	mi44_div u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .num(num),
		.den({dmag, 1'b0}), .stat(dstat), .quot(quot)
	);

	logic hi;
	logic [31:0] lim, val;
	logic sat;
	always_comb begin
		hi  = |quot[NUM_W-1:32];
		lim = cneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		sat = 1'b0;
		if (sing_q) begin
			val = (k_q[3:2] == k_q[1:0]) ? (32'd1 << FRAC_BITS) : 32'd0;
		end else if (hi || quot[31:0] > lim) begin
			val = lim;
			sat = 1'b1;
		end else begin
			val = cneg ? -quot[31:0] : quot[31:0];
		end
	end

	assign out_fire = (st_q == ST_EMIT) && (!ov_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_LOAD;
			ld_q    <= '0;
			thr_q   <= THR_W'(1);
			k_q     <= '0;
			e_cnt_q <= '0;
			ph_q    <= '0;
			ov_q    <= 1'b0;
			sing_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_valid && cfg_ready)
				thr_q <= cfg_data[THR_W-1:0];
			if (out_fire)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
			case (st_q)
				ST_LOAD: begin
					if (s_tvalid) ld_q <= ld_q + 4'd1;
					e_cnt_q <= '0;
					k_q     <= '0;
				end
				ST_MRD: begin
					e_cnt_q <= e_cnt_q + 4'd1;
					ph_q    <= '0;
				end
				ST_MWAIT: if (!mul_busy_q) begin
					if (ph_q == 4'd8) begin
						ph_q    <= '0;
						e_cnt_q <= '0;
						k_q     <= k_q + 4'd1;
					end else begin
						ph_q <= ph_q + 4'd1;
					end
				end
				ST_DWAIT: if (!mul_busy_q) k_q <= (k_q == 4'd3) ? 4'd0 : k_q + 4'd1;
				ST_CHECK: sing_q <= dmag <= (DET_W'(thr_q) << (3 * FRAC_BITS));
				ST_EMIT: if (out_fire) k_q <= k_q + 4'd1;
				default: ;
			endcase
		end
	end

	// datapath: element capture, collect each product, accumulate minors and determinant, load the output register
	always_ff @(posedge clk) begin
		if (st_q == ST_MRD && e_cnt_q != 4'd0)
			e_q[e_cnt_q - 4'd1] <= $signed(rd_q);
		if (st_q == ST_MWAIT && !mul_busy_q) begin
			case (ph_q)
				4'd0: acc_q <= MIN_W'(prod);
				4'd1: t_q   <= acc_q - MIN_W'(prod);
				4'd2: acc_q <= MIN_W'(prod);
				4'd3: p2_q  <= acc_q - MIN_W'(prod);
				4'd4: acc_q <= MIN_W'(prod);
				4'd5: p3_q  <= acc_q - MIN_W'(prod);
				4'd6: acc_q <= MIN_W'(prod);
				4'd7: acc_q <= acc_q - MIN_W'(prod);
				4'd8: mn_q[k_q] <= acc_q + MIN_W'(prod);
				default: ;
			endcase
		end
		if (st_q == ST_DRD && k_q == 4'd0)
			det_q <= '0;
		if (st_q == ST_DWAIT && !mul_busy_q)
			det_q <= k_q[0] ? det_q - prod : det_q + prod;
		if (out_fire) begin
			od_q <= val;
			ou_q <= {sat, sing_q};
			ol_q <= (k_q == 4'd15);
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tuser  = ou_q;
	assign m_tlast  = ol_q;
endmodule

[rtl/core/mi44_div.sv]
module mi44_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mi44_pkg::mi44_div_req_t     req,
	input  logic [mi44_pkg::NUM_W-1:0]  num,
	input  logic [mi44_pkg::DET_W:0]    den,
	output mi44_pkg::mi44_div_stat_t    stat,
	output logic [mi44_pkg::NUM_W-1:0]  quot
);
	import mi44_pkg::*;

	logic [NUM_W-1:0] n_q;
	logic [DET_W+1:0] rem_q;
	logic [7:0]       cnt_q;
	logic             busy_q, done_q;
	logic [DET_W+1:0] sh;
	logic [DET_W+1:0] df;

	assign sh = {rem_q[DET_W:0], n_q[NUM_W-1]};
	assign df = sh - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 8'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q   <= num;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NUM_W-2:0], 1'b0};
			if (!df[DET_W+1]) begin
				rem_q <= df;
				quot  <= {quot[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				quot  <= {quot[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

[rtl/core/mi44_chk.sv]
module mi44_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");
	a_sat_sing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("singular result marked saturated");
	a_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken while results pending");
endmodule

bind matrix_inverse_4x4_top mi44_chk u_chk (.*);

[dv/matrix_inverse_4x4_checker.sv]
`timescale 1ns / 100ps

module matrix_inverse_4x4_checker
	import mi44_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          inverse_pending
);

	localparam int FRAC = 16;

	typedef struct {
		logic [31:0] value;
		logic        singular;
		logic        saturated;
		logic        last;
	} inv_elem_t;

	inv_elem_t           inverse_q[$];
	logic [ELEM_W-1:0]   mat[N_ELEM];
	logic [IDX_W-1:0]    load_idx;
	logic [THR_W-1:0]    det_thr;

	assign inverse_pending = inverse_q.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("mismatch %s: got %h, expected %h (at %0t)", what, got, exp, $time);
		fail_count++;
	endtask

	function automatic logic signed [191:0] wide(input logic [31:0] v);
		return {{160{v[31]}}, v};
	endfunction

	// 3x3 cofactor minor with row rr and column cc removed, exact
	function automatic logic signed [191:0] minor3(input int rr, input int cc);
		logic signed [191:0] e[9];
		logic signed [191:0] a, b, d;
		int k;
		k = 0;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				if (r != rr && c != cc) begin
					e[k] = wide(mat[r*4+c]);
					k++;
				end
		a = e[4]*e[8] - e[5]*e[7];
		b = e[3]*e[8] - e[5]*e[6];
		d = e[3]*e[7] - e[4]*e[6];
		return e[0]*a - e[1]*b + e[2]*d;
	endfunction

	task automatic predict_inverse();
		logic signed [191:0] mn[16];
		logic signed [191:0] det;
		logic [191:0] dmag, thr, den, num, q, cmag, lim;
		logic sing, neg;
		inv_elem_t x;
		int r, c;
		det = '0;
		for (int k = 0; k < 16; k++) mn[k] = minor3(k >> 2, k & 3);
		for (int j = 0; j < 4; j++)
			if (j & 1) det = det - mn[j] * wide(mat[j]);
			else       det = det + mn[j] * wide(mat[j]);
		dmag = det[191] ? -det : det;
		thr  = {161'b0, det_thr} << (3*FRAC);
		sing = dmag <= thr;
		den  = dmag << 1;
		for (int k = 0; k < 16; k++) begin
			r = k >> 2;
			c = k & 3;
			x.saturated = 1'b0;
			x.singular  = sing;
			x.last      = (k == 15);
			if (sing) begin
				x.value = (r == c) ? (32'd1 << FRAC) : 32'd0;
			end else begin
				neg  = mn[c*4+r][191] ^ det[191] ^ 1'((r + c) & 1);
				cmag = mn[c*4+r][191] ? -mn[c*4+r] : mn[c*4+r];
				num  = (cmag << (2*FRAC + 1)) + dmag;
				q    = num / den;
				lim  = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
				if (q > lim) begin
					x.saturated = 1'b1;
					x.value     = lim[31:0];
				end else begin
					x.value = neg ? -q[31:0] : q[31:0];
				end
			end
			inverse_q.push_back(x);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_idx <= '0;
			det_thr  <= THR_W'(1);
			fail_count = 0;
			inverse_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) det_thr <= cfg_data[THR_W-1:0];
			if (s_tvalid && s_tready) begin
				mat[load_idx] = s_tdata;
				load_idx <= load_idx + IDX_W'(1);
				if (load_idx == IDX_W'(N_ELEM - 1)) predict_inverse();
			end
			if (m_tvalid && m_tready) begin
				if (inverse_q.size() == 0) begin
					$display("unexpected result %h (at %0t)", m_tdata, $time);
					fail_count++;
				end else begin
					inv_elem_t x;
					x = inverse_q.pop_front();
					if (m_tdata !== x.value)
						report("inverse_element", m_tdata, x.value);
					if (m_tuser[0] !== x.singular)
						report("singular", 32'(m_tuser[0]), 32'(x.singular));
					if (m_tuser[1] !== x.saturated)
						report("saturated", 32'(m_tuser[1]), 32'(x.saturated));
					if (m_tlast !== x.last)
						report("last", 32'(m_tlast), 32'(x.last));
				end
			end
		end
	end

endmodule

[dv/tb_matrix_inverse_4x4_top.sv]
`timescale 1ns / 100ps

module tb_matrix_inverse_4x4_top;
	import mi44_pkg::*;

	typedef enum int {MK_SMALL, MK_FULL, MK_DIAG, MK_DUP_ROW} mat_kind_t;

	localparam int STALL_LIMIT = 8000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid, cfg_ready;
	logic [31:0] cfg_data;
	int          fail_count, inverse_pending;
	int          stall_cycles = 0;
	bit          no_idle;
	logic [31:0] mat[16];

	matrix_inverse_4x4_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	matrix_inverse_4x4_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .inverse_pending(inverse_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: random hold-off before each result
	initial begin
		int gap;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			gap = no_idle ? 0 : $urandom_range(0, 19);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_element(input logic [31:0] v);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_matrix();
		for (int i = 0; i < 16; i++) send_element(mat[i]);
		s_tvalid <= 1'b0;
	endtask

	// wait for the inverse to drain, then write the threshold
	task automatic write_threshold(input logic [31:0] v);
		while (inverse_pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic fill_diag(input logic [31:0] d);
		for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? d : 32'd0;
	endtask

	function automatic logic [31:0] small_val();
		return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
	endfunction

	task automatic build_random(input mat_kind_t kind);
		for (int i = 0; i < 16; i++) begin
			case (kind)
				MK_FULL: mat[i] = $urandom;
				MK_DIAG: mat[i] = (i % 5 == 0) ? small_val() + 32'h0010_0000 : small_val();
				default: mat[i] = small_val();
			endcase
		end
		if (kind == MK_DUP_ROW)
			for (int c = 0; c < 4; c++) mat[8+c] = mat[c];
	endtask

	initial begin
		int n;
		mat_kind_t kind;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		no_idle   = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// identity, then the most negative diagonal with extreme off-diagonal corner
		write_threshold(32'd1);
		fill_diag(32'h0001_0000);
		send_matrix();
		fill_diag(32'h8000_0000);
		mat[3] = 32'h7FFF_FFFF;
		send_matrix();
		// tiny diagonal: singular at threshold 1, saturates at threshold 0
		fill_diag(32'd1);
		send_matrix();
		write_threshold(32'd0);
		send_matrix();

		for (n = 0; n < 16; n++) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 4))
					0: write_threshold(32'd0);
					1: write_threshold(32'hFFFF_FFFF);
					2: write_threshold(32'd1);
					3: write_threshold($urandom_range(0, 64));
					default: write_threshold($urandom);
				endcase
			end
			no_idle = ($urandom_range(0, 3) == 0);
			kind = mat_kind_t'($urandom_range(0, 3));
			build_random(kind);
			send_matrix();
		end
		no_idle = 1'b0;

		while (inverse_pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
